FILE: hdl/pts_pkg.sv
package pts_pkg;

	localparam int NUM_TASKS_DEF = 8;
	localparam int PRIO_BITS_DEF = 3;

	localparam int TASK_W  = 3;
	localparam int PRIO_W  = 3;
	localparam int STAT_W  = 2;
	localparam int WAKE_W  = 32;
	localparam int SLICE_W = 16;
	localparam int APB_AW  = 1;
	localparam int APB_DW  = 32;

	localparam logic [SLICE_W-1:0] SLICE_RST = 16'd10;

	localparam logic [STAT_W-1:0] ST_SUSPENDED = 2'd0;
	localparam logic [STAT_W-1:0] ST_READY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_RUNNING   = 2'd2;
	localparam logic [STAT_W-1:0] ST_BLOCKED   = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SCHED = 1'b1;

	localparam logic [APB_AW-1:0] REG_SLICE = 1'b0;

endpackage

FILE: hdl/pts_table.sv
module pts_table #(
	parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
	parameter int PRIO_BITS = pts_pkg::PRIO_BITS_DEF,
	localparam int IDX_W = $clog2(NUM_TASKS),
	localparam int ENT_W = 1 + pts_pkg::STAT_W + PRIO_BITS + pts_pkg::WAKE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [ENT_W-1:0] wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [ENT_W-1:0] rdata
);
	import pts_pkg::*;

	// slot 0 holds the idle task, present and running out of reset
	localparam logic [ENT_W-1:0] RST_ENT0 =
		{1'b1, ST_RUNNING, {PRIO_BITS{1'b0}}, {WAKE_W{1'b0}}};

	logic [ENT_W-1:0]     mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] vld_q;
	logic [ENT_W-1:0]     rd_s1;
	logic                 rvld_s1;
	logic [IDX_W-1:0]     raddr_s1;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rd_s1    <= mem[raddr];
			raddr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rvld_s1 <= vld_q[raddr];
		end
	end

	// never-written slots read back as their reset contents
	always_comb begin
		if (rvld_s1)
			rdata = rd_s1;
		else if (raddr_s1 == '0)
			rdata = RST_ENT0;
		else
			rdata = '0;
	end

endmodule

FILE: hdl/pts_ctrl.sv
module pts_ctrl #(
	parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
	parameter int PRIO_BITS = pts_pkg::PRIO_BITS_DEF,
	localparam int IDX_W = $clog2(NUM_TASKS),
	localparam int ENT_W = 1 + pts_pkg::STAT_W + PRIO_BITS + pts_pkg::WAKE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [pts_pkg::TASK_W-1:0]  entry_index,
	input  logic                        entry_valid,
	input  logic [pts_pkg::STAT_W-1:0]  entry_state,
	input  logic [pts_pkg::PRIO_W-1:0]  entry_priority,
	input  logic [pts_pkg::WAKE_W-1:0]  entry_wake_time,
	input  logic [pts_pkg::WAKE_W-1:0]  now_tick,
	input  logic [pts_pkg::SLICE_W-1:0] slice_len,
	output logic                        tbl_we,
	output logic [IDX_W-1:0]            tbl_waddr,
	output logic [ENT_W-1:0]            tbl_wdata,
	output logic                        tbl_re,
	output logic [IDX_W-1:0]            tbl_raddr,
	input  logic [ENT_W-1:0]            tbl_rdata,
	output logic                        done,
	output logic                        switched,
	output logic [pts_pkg::TASK_W-1:0]  from_task,
	output logic [pts_pkg::TASK_W-1:0]  to_task,
	output logic [pts_pkg::SLICE_W-1:0] slice_value
);
	import pts_pkg::*;

	typedef struct packed {
		logic                 present;
		logic [STAT_W-1:0]    status;
		logic [PRIO_BITS-1:0] level;
		logic [WAKE_W-1:0]    wake;
	} ent_t;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_LAST    = 3'd2;
	localparam logic [2:0] S_DEMOTE  = 3'd3;
	localparam logic [2:0] S_PROMOTE = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     run_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [PRIO_BITS-1:0] best_lvl_q;
	ent_t                 best_ent_q;
	ent_t                 zero_ent_q;
	ent_t                 run_ent_q;
	logic [WAKE_W-1:0]    now_q;
	logic                 proc_vld_s1;
	logic [IDX_W-1:0]     proc_idx_s1;
	logic                 done_q;
	logic                 switched_q;
	logic [TASK_W-1:0]    from_q;
	logic [TASK_W-1:0]    to_q;
	logic [SLICE_W-1:0]   slice_q;

	ent_t             rd_ent;
	ent_t             nxt_ent;
	ent_t             wr_ent;
	ent_t             wd_ent;
	ent_t             pick_ent;
	logic             woke;
	logic             cand;
	logic             accept;
	logic             in_range;
	logic [IDX_W-1:0] pick_idx;
	logic             do_switch;
	logic             demote;
	logic             fix_zero;

	assign rd_ent = ent_t'(tbl_rdata);
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign in_range = int'(entry_index) < NUM_TASKS;
	assign wr_ent   = '{present: entry_valid, status: entry_state,
	                    level: PRIO_BITS'(entry_priority), wake: entry_wake_time};

	// wake-up check on the entry coming back from the table
	always_comb begin
		nxt_ent = rd_ent;
		woke    = rd_ent.present && (rd_ent.status == ST_BLOCKED) && (now_q >= rd_ent.wake);
		if (woke)
			nxt_ent.status = ST_READY;
		// >= lets the later slot win a tie
		cand = proc_vld_s1 && nxt_ent.present && (nxt_ent.status == ST_READY) &&
			(nxt_ent.level >= best_lvl_q);
	end

	assign pick_idx  = found_q ? best_idx_q : '0;
	assign pick_ent  = found_q ? best_ent_q : zero_ent_q;
	assign do_switch = (pick_idx != run_q);
	assign demote    = do_switch && (run_ent_q.status == ST_RUNNING);
	assign fix_zero  = !found_q && (zero_ent_q.status != ST_RUNNING);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = proc_idx_s1;
		wd_ent    = nxt_ent;
		tbl_re    = 1'b0;
		tbl_raddr = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_WRITE) && in_range) begin
					tbl_we    = 1'b1;
					tbl_waddr = IDX_W'(entry_index);
					wd_ent    = wr_ent;
				end
			end
			S_SCAN: begin
				tbl_re = 1'b1;
				tbl_we = proc_vld_s1 && woke;
			end
			S_LAST: begin
				tbl_we = proc_vld_s1 && woke;
			end
			S_DEMOTE: begin
				tbl_we        = demote;
				tbl_waddr     = run_q;
				wd_ent        = run_ent_q;
				wd_ent.status = ST_READY;
			end
			S_PROMOTE: begin
				if (do_switch) begin
					tbl_we        = 1'b1;
					tbl_waddr     = pick_idx;
					wd_ent        = pick_ent;
					wd_ent.status = ST_RUNNING;
				end else if (fix_zero) begin
					tbl_we        = 1'b1;
					tbl_waddr     = '0;
					wd_ent        = zero_ent_q;
					wd_ent.status = ST_READY;
				end
			end
			default: ;
		endcase
	end

	assign tbl_wdata = wd_ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			run_q       <= '0;
			found_q     <= 1'b0;
			proc_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			proc_vld_s1 <= (state_q == S_SCAN);
			if (cand)
				found_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_SCHED) begin
							state_q <= S_SCAN;
							cnt_q   <= '0;
							found_q <= 1'b0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST_IDX)
						state_q <= S_LAST;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_LAST:   state_q <= S_DEMOTE;
				S_DEMOTE: state_q <= S_PROMOTE;
				S_PROMOTE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					run_q   <= pick_idx;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		proc_idx_s1 <= cnt_q;
		if (accept && (cmd == CMD_SCHED)) begin
			now_q      <= now_tick;
			best_lvl_q <= '0;
			best_idx_q <= '0;
		end
		if (cand) begin
			best_idx_q <= proc_idx_s1;
			best_lvl_q <= nxt_ent.level;
			best_ent_q <= nxt_ent;
		end
		if (proc_vld_s1 && (proc_idx_s1 == '0))
			zero_ent_q <= nxt_ent;
		if (proc_vld_s1 && (proc_idx_s1 == run_q))
			run_ent_q <= nxt_ent;
		if (accept && (cmd == CMD_WRITE)) begin
			switched_q <= 1'b0;
			from_q     <= TASK_W'(run_q);
			to_q       <= TASK_W'(run_q);
			slice_q    <= '0;
		end
		if (state_q == S_PROMOTE) begin
			switched_q <= do_switch;
			from_q     <= TASK_W'(run_q);
			to_q       <= TASK_W'(pick_idx);
			slice_q    <= do_switch ? slice_len : '0;
		end
	end

	assign done        = done_q;
	assign switched    = switched_q;
	assign from_task   = from_q;
	assign to_task     = to_q;
	assign slice_value = slice_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we && tbl_re |-> tbl_waddr != tbl_raddr)
		else $error("table write and read hit the same slot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while a pass is in progress");

	a_promote_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROMOTE |=> done)
		else $error("pass finished without a result");

	a_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		done && !switched |-> from_task == to_task && slice_value == '0)
		else $error("no-switch result carries a task change or slice");

	a_run_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(run_q) |-> $past(state_q) == S_PROMOTE)
		else $error("running task changed outside a pass");

endmodule

FILE: hdl/priority_task_scheduler.sv
// Priority task scheduler: decision logic of a fixed-priority preemptive kernel.
// Requests enter on start/busy: a request is taken on a clock edge with start high
// and busy low. cmd selects a slot write (entry_* fields) or a scheduling pass at
// now_tick. Every request yields one result, strobed by done for a single cycle:
// switched, from_task, to_task and slice_value.
// A slot write reports on the cycle after acceptance. A pass reads the task
// table one slot per cycle through its single read port, writes back wake-ups on
// the fly, then passes through the LAST, DEMOTE and PROMOTE states, demoting the
// old task and promoting the new one, with busy high meanwhile. Requests are handled
// one at a time; a new request may be taken on the cycle done is high.
// The results cannot be held off; done is a pulse and must be sampled when high.
// slice_length sits at APB address 0. The user must write it only while the block
// is idle; the block itself does not enforce this. Reset (arst_n low) restores
// slice_length to 10, makes the idle task (slot 0) present and running and all
// other slots empty; no clearing pass is needed.
module priority_task_scheduler #(
	parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
	parameter int PRIO_BITS = pts_pkg::PRIO_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pts_pkg::APB_AW-1:0]  paddr,
	input  logic [pts_pkg::APB_DW-1:0]  pwdata,
	output logic [pts_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [pts_pkg::TASK_W-1:0]  entry_index,
	input  logic                        entry_valid,
	input  logic [pts_pkg::STAT_W-1:0]  entry_state,
	input  logic [pts_pkg::PRIO_W-1:0]  entry_priority,
	input  logic [pts_pkg::WAKE_W-1:0]  entry_wake_time,
	input  logic [pts_pkg::WAKE_W-1:0]  now_tick,
	output logic                        done,
	output logic                        switched,
	output logic [pts_pkg::TASK_W-1:0]  from_task,
	output logic [pts_pkg::TASK_W-1:0]  to_task,
	output logic [pts_pkg::SLICE_W-1:0] slice_value
);
	import pts_pkg::*;

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int ENT_W = 1 + STAT_W + PRIO_BITS + WAKE_W;

	logic [SLICE_W-1:0] slice_len_q;
	logic               tbl_we;
	logic [IDX_W-1:0]   tbl_waddr;
	logic [ENT_W-1:0]   tbl_wdata;
	logic               tbl_re;
	logic [IDX_W-1:0]   tbl_raddr;
	logic [ENT_W-1:0]   tbl_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slice_len_q <= SLICE_RST;
		else if (psel && penable && pwrite && (paddr == REG_SLICE))
			slice_len_q <= pwdata[SLICE_W-1:0];
	end

	assign prdata = (paddr == REG_SLICE) ? APB_DW'(slice_len_q) : '0;

	pts_table #(
		.NUM_TASKS(NUM_TASKS),
		.PRIO_BITS(PRIO_BITS)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	pts_ctrl #(
		.NUM_TASKS(NUM_TASKS),
		.PRIO_BITS(PRIO_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.entry_index    (entry_index),
		.entry_valid    (entry_valid),
		.entry_state    (entry_state),
		.entry_priority (entry_priority),
		.entry_wake_time(entry_wake_time),
		.now_tick       (now_tick),
		.slice_len      (slice_len_q),
		.tbl_we         (tbl_we),
		.tbl_waddr      (tbl_waddr),
		.tbl_wdata      (tbl_wdata),
		.tbl_re         (tbl_re),
		.tbl_raddr      (tbl_raddr),
		.tbl_rdata      (tbl_rdata),
		.done           (done),
		.switched       (switched),
		.from_task      (from_task),
		.to_task        (to_task),
		.slice_value    (slice_value)
	);

endmodule
